// ===== sv/tlbs_pkg.sv =====
package tlbs_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int KEY_W         = 32;
  localparam int LEN_W         = 8;
  localparam int IDX_W         = 7;
  localparam int POS_W         = 8;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_LINEAR = 2'd1,
    OP_BINARY = 2'd2
  } op_t;

endpackage

// ===== sv/tlbs_ram.sv =====
module tlbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/tlbs_ctrl.sv =====
module tlbs_ctrl import tlbs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        op,
  input  logic signed [KEY_W-1:0] search_key,
  input  logic [CW-1:0]     len,
  output logic              busy,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [KEY_W-1:0]  rd_data,
  output logic              done,
  output logic [POS_W-1:0]  position,
  output logic              found
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIN,
    S_BIN_RD,
    S_BIN_CMP
  } state_t;

  localparam logic signed [CW:0] ONE_S = (CW+1)'(1);

  state_t state;

  logic signed [KEY_W-1:0] key;
  logic [CW-1:0]           rd_idx;
  logic                    cmp_valid;
  logic [CW-1:0]           cmp_idx;
  logic signed [CW:0]      lo;
  logic signed [CW:0]      hi;
  logic signed [CW:0]      mid;

  logic                    issue;
  logic                    in_range;
  logic signed [CW+1:0]    mid_sum;
  logic signed [CW:0]      mid_next;
  logic signed [KEY_W-1:0] entry;

  assign busy     = (state != S_IDLE);
  assign issue    = (rd_idx < len);
  assign in_range = (lo <= hi);
  // lo and hi are both non-negative whenever a probe is issued
  assign mid_sum  = (CW+2)'(lo) + (CW+2)'(hi);
  assign mid_next = (CW+1)'(mid_sum >>> 1);
  assign entry    = $signed(rd_data);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(rd_idx);
    case (state)
      S_LIN: begin
        rd_en   = issue;
        rd_addr = AW'(rd_idx);
      end
      S_BIN_RD: begin
        rd_en   = in_range;
        rd_addr = AW'(mid_next);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            key <= search_key;
            case (op_t'(op))
              OP_LINEAR: begin
                rd_idx    <= '0;
                cmp_valid <= 1'b0;
                state     <= S_LIN;
              end
              OP_BINARY: begin
                lo    <= '0;
                hi    <= $signed({1'b0, len}) - ONE_S;
                state <= S_BIN_RD;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_LIN: begin
          // reads run one ahead of the compare
          cmp_valid <= issue;
          cmp_idx   <= rd_idx;
          if (issue) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (cmp_valid && (entry == key)) begin
            done     <= 1'b1;
            found    <= 1'b1;
            position <= POS_W'(32'(cmp_idx) + 32'd1);
            state    <= S_IDLE;
          end else if (!issue && !cmp_valid) begin
            done     <= 1'b1;
            found    <= 1'b0;
            position <= '0;
            state    <= S_IDLE;
          end
        end
        S_BIN_RD: begin
          if (in_range) begin
            mid   <= mid_next;
            state <= S_BIN_CMP;
          end else begin
            done     <= 1'b1;
            found    <= 1'b0;
            position <= '0;
            state    <= S_IDLE;
          end
        end
        S_BIN_CMP: begin
          if (key < entry) begin
            hi    <= mid - ONE_S;
            state <= S_BIN_RD;
          end else if (key > entry) begin
            lo    <= mid + ONE_S;
            state <= S_BIN_RD;
          end else begin
            done     <= 1'b1;
            found    <= 1'b1;
            position <= POS_W'(mid + ONE_S);
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/table_linear_binary_search.sv =====
// Write beats are written in the accept cycle; busy stays low and no strobe follows.
// Linear search: done strobes once a matching entry is compared, or once all length
// entries are read on a miss; one table read per cycle, one RAM read port. Binary search:
// each probe is a RAM read state, then a compare state; a hit strobes from the compare,
// a miss from the read state. Busy drops in the strobe cycle, so the next beat may be
// accepted then; results cannot be held off. rst (sync) clears control and table_length.
module table_linear_binary_search import tlbs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              op,
  input  logic [IDX_W-1:0]        entry_index,
  input  logic signed [KEY_W-1:0] entry_value,
  input  logic signed [KEY_W-1:0] search_key,
  input  logic                    cfg_wr_en,
  input  logic [LEN_W-1:0]        cfg_wr_data,
  output logic                    done,
  output logic [POS_W-1:0]        position,
  output logic                    found
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [LEN_W-1:0] table_length;
  logic [CW-1:0]    len;
  logic             wr_en;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= '0;
    end else if (cfg_wr_en) begin
      table_length <= cfg_wr_data;
    end
  end

  assign len = (32'(table_length) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(table_length);

  assign wr_en = start && !busy && (op == OP_WRITE) && (32'(entry_index) < 32'(DEPTH));

  tlbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(entry_index)),
    .wr_data (entry_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tlbs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (op),
    .search_key (search_key),
    .len        (len),
    .busy       (busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .done       (done),
    .position   (position),
    .found      (found)
  );

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_found_pos: assert property (@(posedge clk) disable iff (rst)
    done |-> (found == (position != '0)))
    else $error("found and position disagree");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == OP_LINEAR || op == OP_BINARY)) |=> busy)
    else $error("search beat did not raise busy");

  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_WRITE) |=> (!busy && !done))
    else $error("write beat started a search");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import tlbs_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [KEY_W-1:0] INT_MIN32 = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] INT_MAX32 = 32'sh7fff_ffff;
  localparam int FILL_KEEP     = 0;
  localparam int FILL_SORTED   = 1;
  localparam int FILL_SHUFFLED = 2;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] val;
    logic [KEY_W-1:0] key;
  } tbl_beat_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
  } match_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] op = OP_WRITE;
  logic [IDX_W-1:0] entry_index = '0;
  logic signed [KEY_W-1:0] entry_value = '0;
  logic signed [KEY_W-1:0] search_key = '0;
  logic cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic busy, done, found;
  logic [POS_W-1:0] position;

  table_linear_binary_search dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .search_key  (search_key),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .done        (done),
    .position    (position),
    .found       (found)
  );

  always #6 clk = ~clk;

  // predictor state, updated as beats are accepted
  logic signed [KEY_W-1:0] tbl_mirror [DEPTH_DEFAULT];
  int unsigned tbl_len = 0;
  match_t match_q[$];

  // generator's view of the table at queueing time
  logic signed [KEY_W-1:0] gen_vals [DEPTH_DEFAULT];
  bit gen_written [DEPTH_DEFAULT];

  tbl_beat_t pend_q[$];
  tbl_beat_t cur_beat;
  int gap_left = 0;
  bit idle_on = 1'b1;
  int err_count = 0;
  match_t want;

  function automatic logic [POS_W-1:0] lookup_position(logic [1:0] kind,
                                                      logic signed [KEY_W-1:0] key);
    int n, lo, hi, mid;
    n = (tbl_len > DEPTH_DEFAULT) ? DEPTH_DEFAULT : tbl_len;
    if (kind == OP_LINEAR) begin
      for (int i = 0; i < n; i++)
        if (tbl_mirror[i] == key) return POS_W'(i + 1);
      return '0;
    end
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key < tbl_mirror[mid]) hi = mid - 1;
      else if (key > tbl_mirror[mid]) lo = mid + 1;
      else return POS_W'(mid + 1);
    end
    return '0;
  endfunction

  function automatic void apply_beat(tbl_beat_t b);
    match_t r;
    case (b.op)
      OP_WRITE: tbl_mirror[b.idx] = b.val;
      OP_LINEAR, OP_BINARY: begin
        r.position = lookup_position(b.op, b.key);
        r.found = (r.position != 0);
        match_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // driver: a beat moves when start is high and busy is low
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) apply_beat(cur_beat);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (pend_q.size() != 0) begin
          cur_beat = pend_q.pop_front();
          start <= 1'b1;
          op <= cur_beat.op;
          entry_index <= cur_beat.idx;
          entry_value <= cur_beat.val;
          search_key <= cur_beat.key;
          if (!idle_on) gap_left = 0;
          else case ($urandom_range(9))
            0, 1, 2, 3, 4: gap_left = 0;
            5, 6, 7: gap_left = $urandom_range(1, 3);
            default: gap_left = $urandom_range(8, 40);
          endcase
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off, one beat per strobe
  always @(posedge clk) begin
    if (!rst && done) begin
      if (match_q.size() == 0) begin
        $error("unexpected result: position %0d found %0b", position, found);
        err_count++;
      end else begin
        want = match_q.pop_front();
        if (position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, position);
          err_count++;
        end
        if (found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, found);
          err_count++;
        end
      end
    end
  end

  function automatic void queue_beat(logic [1:0] kind, logic [IDX_W-1:0] idx,
                                     logic [KEY_W-1:0] val, logic [KEY_W-1:0] key);
    tbl_beat_t b;
    b.op = kind;
    b.idx = idx;
    b.val = val;
    b.key = key;
    if (kind == OP_WRITE) begin
      gen_vals[idx] = val;
      gen_written[idx] = 1'b1;
    end
    pend_q.push_back(b);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int n);
    int k;
    k = $urandom_range(9);
    if (n > 0 && k < 6) return gen_vals[$urandom_range(n - 1)];
    if (n > 0 && k < 8) return gen_vals[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
    if (k == 8) return $urandom_range(1) ? INT_MAX32 : INT_MIN32;
    return $urandom;
  endfunction

  // wait until all beats are in, all results are out and the block is quiet
  task automatic drain();
    @(negedge clk);
    while (pend_q.size() != 0 || start) @(negedge clk);
    while (match_q.size() != 0 || busy) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_length(int len);
    drain();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= LEN_W'(len);
    tbl_len = len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic fill_table(int n, bit sorted);
    longint v, step_max;
    if (sorted) begin
      case ($urandom_range(2))
        0: begin v = int'($urandom); step_max = 3; end
        1: begin v = -64'sd2147483648 + $urandom_range(1000); step_max = 64'd4294967295 / n; end
        default: begin v = int'($urandom); step_max = 1000; end
      endcase
      for (int i = 0; i < n; i++) begin
        queue_beat(OP_WRITE, IDX_W'(i), (v > 64'sd2147483647) ? INT_MAX32 : KEY_W'(v),
                   $urandom);
        v += longint'($urandom_range(32'(step_max)));
      end
    end else begin
      for (int i = 0; i < n; i++)
        queue_beat(OP_WRITE, IDX_W'(i),
                   $urandom_range(1) ? $urandom : KEY_W'(int'($urandom_range(8)) - 4),
                   $urandom);
    end
  endtask

  task automatic run_phase(int len, int n_beats, int mode, bit idle);
    int n;
    bit fill;
    n = (len > DEPTH_DEFAULT) ? DEPTH_DEFAULT : len;
    set_length(len);
    idle_on = idle;
    fill = (mode != FILL_KEEP);
    for (int i = 0; i < n; i++)
      if (!gen_written[i]) fill = 1'b1;
    if (fill && n > 0) fill_table(n, mode != FILL_SHUFFLED);
    for (int i = 0; i < n_beats; i++) begin
      case ($urandom_range(99)) inside
        [0:39]:  queue_beat(OP_LINEAR, IDX_W'($urandom), $urandom, pick_key(n));
        [40:79]: queue_beat(OP_BINARY, IDX_W'($urandom), $urandom, pick_key(n));
        [80:91]: queue_beat(OP_WRITE, IDX_W'($urandom), $urandom, $urandom);
        default: queue_beat(OP_UNUSED, IDX_W'($urandom), $urandom, $urandom);
      endcase
    end
  endtask

  initial begin
    logic signed [KEY_W-1:0] seed_vals [8];
    seed_vals = '{INT_MIN32, -100, -1, 0, 0, 5, 1000, INT_MAX32};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table after reset: both searches miss; unused opcode is dropped
    queue_beat(OP_LINEAR, 0, 0, 0);
    queue_beat(OP_BINARY, 0, 0, INT_MIN32);
    queue_beat(OP_UNUSED, '1, '1, '1);
    foreach (seed_vals[i]) queue_beat(OP_WRITE, IDX_W'(i), seed_vals[i], 0);
    set_length(8);
    queue_beat(OP_LINEAR, 0, 0, INT_MIN32);
    queue_beat(OP_LINEAR, 0, 0, INT_MAX32);
    queue_beat(OP_LINEAR, 0, 0, 0);          // duplicate: first hit wins
    queue_beat(OP_LINEAR, 0, 0, 7);
    queue_beat(OP_BINARY, 0, 0, INT_MIN32);
    queue_beat(OP_BINARY, 0, 0, INT_MAX32);
    queue_beat(OP_BINARY, 0, 0, 5);
    queue_beat(OP_BINARY, 0, 0, 1);
    queue_beat(OP_BINARY, 0, 0, INT_MAX32 - 1);

    run_phase(1, 10, FILL_SORTED, 1'b1);
    run_phase(128, 25, FILL_SORTED, 1'b0);
    run_phase(255, 25, FILL_KEEP, 1'b1);     // length past depth clips to depth
    run_phase($urandom_range(2, 16), 20, FILL_SORTED, 1'b1);
    run_phase($urandom_range(2, 40), 20, FILL_SHUFFLED, 1'b1);
    run_phase(0, 10, FILL_KEEP, 1'b1);
    for (int p = 0; p < 5; p++)
      run_phase($urandom_range(1, 24), 8,
                ($urandom_range(3) != 0) ? FILL_SORTED : FILL_SHUFFLED, $urandom_range(1));
    run_phase(129, 10, FILL_KEEP, 1'b1);

    drain();
    repeat (140) @(negedge clk);
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #(64'd24_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tlbs_pkg.sv
sv/tlbs_ram.sv
sv/tlbs_ctrl.sv
sv/table_linear_binary_search.sv
tb/tb_top.sv
